### rtl/mpe_pkg.sv
package mpe_pkg;

    localparam int MAX_BOUNDARY = 64;
    localparam int DELIM_HEAD   = 4;
    localparam int WIN_DEPTH    = MAX_BOUNDARY + DELIM_HEAD;
    localparam int LEN_W        = $clog2(WIN_DEPTH + 1);
    localparam int BIDX_W       = 6;
    localparam int HDR_W        = 16;
    localparam int CNT_W        = 32;

    typedef logic [7:0] t_byte;

    localparam t_byte CR_BYTE = 8'h0D;

    // Delimiter prefix CR LF '-' '-' and the header terminator CR LF CR LF.
    localparam t_byte DELIM_PREFIX [DELIM_HEAD] = '{8'h0D, 8'h0A, 8'h2D, 8'h2D};
    localparam t_byte BLANK_LINE   [DELIM_HEAD] = '{8'h0D, 8'h0A, 8'h0D, 8'h0A};

    typedef enum logic [1:0] {
        CMD_LOAD    = 2'd0,
        CMD_BODY    = 2'd1,
        CMD_FINISH  = 2'd2,
        CMD_RESTART = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_COMPLETE   = 2'd0,
        ST_INCOMPLETE = 2'd1,
        ST_FAILED     = 2'd2
    } t_status;

    typedef enum logic {
        KIND_PAYLOAD = 1'b0,
        KIND_FINISH  = 1'b1
    } t_kind;

    typedef enum logic {
        REG_BOUNDARY_LENGTH = 1'b0,
        REG_HEADER_LIMIT    = 1'b1
    } t_reg_idx;

    // Per-word result of the header skipper.
    typedef struct packed {
        logic in_payload;
        logic fail;
    } t_hdr_stat;

    // Per-word result of the hold window.
    typedef struct packed {
        logic  release_byte;
        logic  match;
        t_byte data;
    } t_win_stat;

endpackage

### rtl/mpe_header.sv
module mpe_header (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_clear,
    input  logic                  i_step,
    input  mpe_pkg::t_byte        i_byte,
    input  logic                  i_last,
    input  logic [15:0]           i_header_limit,
    output mpe_pkg::t_hdr_stat    o_stat
);
    import mpe_pkg::*;

    logic [2:0]       r_hmatch;
    logic [HDR_W-1:0] r_hbytes;
    logic             r_in_payload;

    logic [2:0]       n_hmatch;
    logic [HDR_W-1:0] n_hbytes;
    logic             w_term;

    always_comb begin
        n_hbytes = (r_hbytes == {HDR_W{1'b1}}) ? r_hbytes : r_hbytes + 1'b1;
        // r_hmatch stays below four while headers are being skipped.
        if (i_byte == BLANK_LINE[r_hmatch[1:0]]) begin
            n_hmatch = r_hmatch + 3'd1;
        end else begin
            n_hmatch = (i_byte == CR_BYTE) ? 3'd1 : 3'd0;
        end
        w_term = (n_hmatch == 3'(DELIM_HEAD));
    end

    assign o_stat.in_payload = r_in_payload;
    assign o_stat.fail = i_step && !w_term && i_last && (n_hbytes > i_header_limit);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_hmatch     <= 3'd0;
            r_hbytes     <= '0;
            r_in_payload <= 1'b0;
        end else if (i_step) begin
            r_hmatch <= n_hmatch;
            r_hbytes <= n_hbytes;
            if (w_term) begin
                r_in_payload <= 1'b1;
            end
        end
    end

endmodule

### rtl/mpe_window.sv
module mpe_window (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_clear,
    input  logic                        i_load,
    input  logic [mpe_pkg::BIDX_W-1:0]  i_load_idx,
    input  mpe_pkg::t_byte              i_byte,
    input  logic                        i_push,
    input  logic [mpe_pkg::LEN_W-1:0]   i_used_len,
    output mpe_pkg::t_win_stat          o_stat
);
    import mpe_pkg::*;

    t_byte            r_bnd [MAX_BOUNDARY];
    t_byte            r_win [WIN_DEPTH];
    logic [LEN_W-1:0] r_fill;

    t_byte            w_next [WIN_DEPTH];
    t_byte            w_ref  [WIN_DEPTH];
    logic [WIN_DEPTH-1:0] w_lane_ok;
    logic [LEN_W-1:0] w_dlen;
    logic [LEN_W-1:0] n_fill;
    logic             w_full;
    logic             w_match;

    assign w_dlen = i_used_len + LEN_W'(DELIM_HEAD);
    assign n_fill = r_fill + 1'b1;

    // Every window position is compared against its delimiter byte at once.
    for (genvar g = 0; g < WIN_DEPTH; g++) begin : g_lane
        if (g < DELIM_HEAD) begin : g_head
            assign w_ref[g] = DELIM_PREFIX[g];
        end else begin : g_bnd
            assign w_ref[g] = r_bnd[g - DELIM_HEAD];
        end
        assign w_next[g]    = (LEN_W'(g) == r_fill) ? i_byte : r_win[g];
        assign w_lane_ok[g] = (LEN_W'(g) >= w_dlen) || (w_next[g] == w_ref[g]);
    end

    assign w_full  = (n_fill == w_dlen);
    assign w_match = i_push && w_full && (&w_lane_ok);

    assign o_stat.match        = w_match;
    assign o_stat.release_byte = i_push && w_full && !w_match;
    assign o_stat.data         = w_next[0];

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_bnd[i_load_idx] <= i_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push && w_full && !w_match) begin
            for (int i = 0; i < WIN_DEPTH - 1; i++) begin
                r_win[i] <= w_next[i + 1];
            end
            r_win[WIN_DEPTH - 1] <= 8'h00;
        end else if (i_push) begin
            r_win <= w_next;
        end
    end

    // Positions at or above the fill count are never read, so a match only rewinds the count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_fill <= '0;
        end else if (i_push) begin
            if (w_match) begin
                r_fill <= '0;
            end else if (w_full) begin
                r_fill <= r_fill;
            end else begin
                r_fill <= n_fill;
            end
        end
    end

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill < LEN_W'(WIN_DEPTH))
        else $error("hold window fill count out of range");

    a_release_needs_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_clear && !w_full) |=> (r_fill == $past(n_fill)))
        else $error("hold window fill did not advance on a push");

    a_match_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_stat.match && o_stat.release_byte))
        else $error("delimiter match and byte release in the same word");

endmodule

### rtl/multipart_payload_extractor_top.sv
// Multipart payload extractor. Each slave word carries a command in tuser: load a boundary
// byte, feed a body byte (tlast marks the end of a received chunk), ask for the finish
// status, or restart. Part headers are skipped through the first CR LF CR LF, then payload
// bytes come out on the master side, always holding back the bytes that could still turn out
// to be the start of the CR LF "--" boundary delimiter; once the delimiter is seen, later body
// bytes are dropped. A finish word answers complete, incomplete or failed with the saturating
// count of released bytes. One word is taken every clock cycle while the master side keeps up,
// and its result, if any, passes from the input register to the result register, with the
// whole hold window compared against the delimiter combinationally between them. A result
// held by the master side stalls the slave side. Writing boundary_length also restarts the
// extractor, and a zero length marks it failed. Boundary bytes have no reset value and must
// be loaded before they are compared.
module multipart_payload_extractor_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Slave stream.
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [15:0] i_s_tdata,   // [5:0] boundary_index, [13:6] data_byte, [15:14] zero
    input  logic [1:0]  i_s_tuser,   // [1:0] command
    input  logic        i_s_tlast,   // chunk_end
    // Master stream.
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [47:0] o_m_tdata,   // [7:0] payload_byte, [9:8] status, [41:10] payload_count
    output logic        o_m_tuser,   // [0] result_kind
    // Register write channel.
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [15:0] i_cfg_data
);
    import mpe_pkg::*;

    // Input stage.
    logic               r_in_valid;
    t_cmd               r_in_cmd;
    logic [BIDX_W-1:0]  r_in_idx;
    t_byte              r_in_byte;
    logic               r_in_last;

    // Registers and extractor state.
    logic [LEN_W-1:0]   r_blen;
    logic [HDR_W-1:0]   r_hlimit;
    logic               r_has_failed;
    logic               r_delim_seen;
    logic [CNT_W-1:0]   r_count;

    // Result stage.
    logic               r_out_valid;
    t_kind              r_out_kind;
    t_byte              r_out_byte;
    t_status            r_out_status;
    logic [CNT_W-1:0]   r_out_count;

    logic               w_go;
    logic               w_cfg_wr;
    logic               w_clear;
    logic               w_failed;
    logic               w_active;
    logic [LEN_W-1:0]   w_used;
    logic [CNT_W-1:0]   n_count;
    t_status            w_fin_status;
    t_hdr_stat          w_hdr;
    t_win_stat          w_win;

    assign w_go       = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || w_go;
    assign o_cfg_ready = 1'b1;
    assign w_cfg_wr   = i_cfg_valid && (t_reg_idx'(i_cfg_index) == REG_BOUNDARY_LENGTH);
    assign w_clear    = w_cfg_wr || (w_go && r_in_cmd == CMD_RESTART);

    assign w_failed = r_has_failed || (r_blen == '0);
    assign w_used   = (r_blen > LEN_W'(MAX_BOUNDARY)) ? LEN_W'(MAX_BOUNDARY) : r_blen;
    assign w_active = w_go && (r_in_cmd == CMD_BODY) && !w_failed && !r_delim_seen;
    assign n_count  = (r_count == {CNT_W{1'b1}}) ? r_count : r_count + 1'b1;

    always_comb begin
        if (w_failed) begin
            w_fin_status = ST_FAILED;
        end else if (r_delim_seen) begin
            w_fin_status = ST_COMPLETE;
        end else begin
            w_fin_status = ST_INCOMPLETE;
        end
    end

    mpe_header u_header (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_clear        (w_clear),
        .i_step         (w_active && !w_hdr.in_payload),
        .i_byte         (r_in_byte),
        .i_last         (r_in_last),
        .i_header_limit (r_hlimit),
        .o_stat         (w_hdr)
    );

    mpe_window u_window (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_clear    (w_clear),
        .i_load     (w_go && r_in_cmd == CMD_LOAD),
        .i_load_idx (r_in_idx),
        .i_byte     (r_in_byte),
        .i_push     (w_active && w_hdr.in_payload && !w_clear),
        .i_used_len (w_used),
        .o_stat     (w_win)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_cmd  <= t_cmd'(i_s_tuser);
            r_in_idx  <= i_s_tdata[5:0];
            r_in_byte <= i_s_tdata[13:6];
            r_in_last <= i_s_tlast;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blen   <= '0;
            r_hlimit <= 16'd8192;
        end else if (i_cfg_valid) begin
            if (t_reg_idx'(i_cfg_index) == REG_BOUNDARY_LENGTH) begin
                r_blen <= i_cfg_data[LEN_W-1:0];
            end else begin
                r_hlimit <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || w_clear) begin
            r_has_failed <= 1'b0;
            r_delim_seen <= 1'b0;
            r_count      <= '0;
        end else begin
            if (w_hdr.fail) begin
                r_has_failed <= 1'b1;
            end
            if (w_win.match) begin
                r_delim_seen <= 1'b1;
            end
            if (w_win.release_byte) begin
                r_count <= n_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_go) begin
            r_out_valid <= (r_in_cmd == CMD_FINISH) || w_win.release_byte;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_go && r_in_cmd == CMD_FINISH) begin
            r_out_kind   <= KIND_FINISH;
            r_out_byte   <= 8'h00;
            r_out_status <= w_fin_status;
            r_out_count  <= r_count;
        end else if (w_go && w_win.release_byte) begin
            r_out_kind   <= KIND_PAYLOAD;
            r_out_byte   <= w_win.data;
            r_out_status <= ST_INCOMPLETE;
            r_out_count  <= n_count;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out_kind;
    assign o_m_tdata  = {6'd0, r_out_count, r_out_status, r_out_byte};

    a_done_no_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_delim_seen |-> !w_win.release_byte)
        else $error("payload word released after the delimiter");

    a_failed_no_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_failed |-> !(w_win.release_byte || w_win.match || w_hdr.fail))
        else $error("body word processed while failed");

    a_payload_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser == KIND_PAYLOAD) |-> (o_m_tdata[9:8] == ST_INCOMPLETE))
        else $error("payload word with a status other than incomplete");

    a_restart_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_clear |=> (r_count == '0 && !r_delim_seen && !r_has_failed))
        else $error("restart did not clear the extractor state");

endmodule
